// File: src/ps2m_pkg.sv
// Shared types and constants for the PS/2 mouse device core.
package ps2m_pkg;

    // Item kinds on the input tuser
    localparam logic [1:0] KIND_HOST   = 2'd0;
    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_MOTION = 2'd2;

    // Host commands
    localparam logic [7:0] CMD_RESET       = 8'hFF;
    localparam logic [7:0] CMD_DEFAULTS    = 8'hF6;
    localparam logic [7:0] CMD_DISABLE     = 8'hF5;
    localparam logic [7:0] CMD_STREAM_MODE = 8'hEA;
    localparam logic [7:0] CMD_ENABLE      = 8'hF4;
    localparam logic [7:0] CMD_GET_ID      = 8'hF2;
    localparam logic [7:0] CMD_STATUS      = 8'hE9;
    localparam logic [7:0] CMD_SET_RATE    = 8'hF3;

    // Replies
    localparam logic [7:0] RSP_ACK     = 8'hFA;
    localparam logic [7:0] RSP_BAT_OK  = 8'hAA;
    localparam logic [7:0] RSP_ZERO    = 8'h00;
    localparam logic [7:0] RSP_STAT_RES  = 8'h02;
    localparam logic [7:0] RSP_STAT_RATE = 8'd100;

    // Mouse types and the sample rate sequences that raise them
    localparam logic [2:0]  TYPE_BASIC = 3'd0;
    localparam logic [2:0]  TYPE_WHEEL = 3'd3;
    localparam logic [2:0]  TYPE_FIVE  = 3'd4;
    localparam logic [23:0] SEQ_WHEEL  = 24'hC86450;
    localparam logic [23:0] SEQ_FIVE   = 24'hC8C850;

    // Packet first byte always carries this bit
    localparam logic [7:0] PKT_SYNC = 8'h08;

    // Wheel byte codes
    localparam logic [7:0] WHL_UP    = 8'h01;
    localparam logic [7:0] WHL_DOWN  = 8'hFF;
    localparam logic [7:0] WHL_LEFT  = 8'h02;
    localparam logic [7:0] WHL_RIGHT = 8'hFE;

    // One queued run of reply bytes; data[0] goes first
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      last_idx;
        logic            stream;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: src/ps2m_front.sv
// Front end: decodes input words, keeps mouse state and builds reply runs.
module ps2m_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_selected,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_host_byte,
    input  logic [7:0]        i_prev_host_byte,
    input  logic [3:0]        i_button_number,
    input  logic              i_button_pressed,
    input  logic [7:0]        i_move_x,
    input  logic [7:0]        i_move_y,
    input  logic [7:0]        i_wheel_h,
    input  logic [7:0]        i_wheel_v,
    output logic              o_push,
    output ps2m_pkg::t_job    o_job
);

    logic        r_streaming, n_streaming;
    logic [2:0]  r_type,      n_type;
    logic [23:0] r_hist,      n_hist;
    logic [7:0]  r_mask,      n_mask;

    logic [3:0]  w_btn_idx;
    logic [7:0]  w_mask_upd;
    logic [7:0]  w_pkt_mask;
    logic [7:0]  w_x, w_y, w_h, w_v;
    logic [7:0]  w_b1, w_b3, w_b4, w_whl;
    logic        w_emit;
    logic [1:0]  w_last;
    logic [3:0][7:0] w_data;

    // button index is one-based; anything outside 1..8 leaves the mask alone
    always_comb begin
        w_btn_idx  = i_button_number - 4'd1;
        w_mask_upd = r_mask;
        if (!w_btn_idx[3]) begin
            w_mask_upd[w_btn_idx[2:0]] = i_button_pressed;
        end
    end

    assign w_pkt_mask = (i_kind == ps2m_pkg::KIND_BUTTON) ? w_mask_upd : r_mask;
    assign w_x = (i_kind == ps2m_pkg::KIND_MOTION) ? i_move_x  : 8'd0;
    assign w_y = (i_kind == ps2m_pkg::KIND_MOTION) ? i_move_y  : 8'd0;
    assign w_h = (i_kind == ps2m_pkg::KIND_MOTION) ? i_wheel_h : 8'd0;
    assign w_v = (i_kind == ps2m_pkg::KIND_MOTION) ? i_wheel_v : 8'd0;

    assign w_b3 = 8'd0 - w_y;
    assign w_b1 = ps2m_pkg::PKT_SYNC | {5'd0, w_pkt_mask[2:0]}
                | {3'd0, w_x[7], 4'd0} | {2'd0, w_b3[7], 5'd0};

    // horizontal wins over vertical
    always_comb begin
        priority if (w_h[7])        w_whl = ps2m_pkg::WHL_LEFT;
        else if (w_h != 8'd0)       w_whl = ps2m_pkg::WHL_RIGHT;
        else if (w_v[7])            w_whl = ps2m_pkg::WHL_UP;
        else if (w_v != 8'd0)       w_whl = ps2m_pkg::WHL_DOWN;
        else                        w_whl = 8'd0;
    end

    assign w_b4 = (r_type == ps2m_pkg::TYPE_FIVE)
                ? {2'b00, w_pkt_mask[4], w_pkt_mask[3], w_whl[3:0]}
                : w_whl;

    always_comb begin
        n_streaming = r_streaming;
        n_type      = r_type;
        n_hist      = r_hist;
        n_mask      = r_mask;
        w_emit      = 1'b0;
        w_last      = 2'd0;
        w_data      = '0;
        w_data[0]   = ps2m_pkg::RSP_ACK;

        unique case (i_kind)
            ps2m_pkg::KIND_HOST: begin
                w_emit = 1'b1;
                if (i_prev_host_byte == ps2m_pkg::CMD_SET_RATE) begin
                    n_hist = {r_hist[15:0], i_host_byte};
                    if (r_type == ps2m_pkg::TYPE_BASIC && n_hist == ps2m_pkg::SEQ_WHEEL) begin
                        n_type = ps2m_pkg::TYPE_WHEEL;
                    end else if (r_type == ps2m_pkg::TYPE_WHEEL
                                 && n_hist == ps2m_pkg::SEQ_FIVE) begin
                        n_type = ps2m_pkg::TYPE_FIVE;
                    end
                end else begin
                    unique case (i_host_byte)
                        ps2m_pkg::CMD_RESET: begin
                            n_streaming = 1'b0;
                            n_type      = ps2m_pkg::TYPE_BASIC;
                            w_data[1]   = ps2m_pkg::RSP_BAT_OK;
                            w_data[2]   = {5'd0, ps2m_pkg::TYPE_BASIC};
                            w_last      = 2'd2;
                        end
                        ps2m_pkg::CMD_DEFAULTS: begin
                            n_streaming = 1'b0;
                            n_type      = ps2m_pkg::TYPE_BASIC;
                        end
                        ps2m_pkg::CMD_DISABLE, ps2m_pkg::CMD_STREAM_MODE: begin
                            n_streaming = 1'b0;
                        end
                        ps2m_pkg::CMD_ENABLE: begin
                            n_streaming = 1'b1;
                        end
                        ps2m_pkg::CMD_GET_ID: begin
                            w_data[1] = {5'd0, r_type};
                            w_last    = 2'd1;
                        end
                        ps2m_pkg::CMD_STATUS: begin
                            w_data[1] = ps2m_pkg::RSP_ZERO;
                            w_data[2] = ps2m_pkg::RSP_STAT_RES;
                            w_data[3] = ps2m_pkg::RSP_STAT_RATE;
                            w_last    = 2'd3;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ps2m_pkg::KIND_BUTTON, ps2m_pkg::KIND_MOTION: begin
                if (i_selected) begin
                    if (i_kind == ps2m_pkg::KIND_BUTTON) begin
                        n_mask = w_mask_upd;
                    end
                    if (r_streaming) begin
                        w_emit    = 1'b1;
                        w_data[0] = w_b1;
                        w_data[1] = w_x;
                        w_data[2] = w_b3;
                        w_data[3] = w_b4;
                        w_last    = (r_type == ps2m_pkg::TYPE_WHEEL
                                     || r_type == ps2m_pkg::TYPE_FIVE) ? 2'd3 : 2'd2;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_streaming <= 1'b0;
            r_type      <= ps2m_pkg::TYPE_BASIC;
            r_hist      <= 24'd0;
            r_mask      <= 8'd0;
        end else if (i_accept) begin
            r_streaming <= n_streaming;
            r_type      <= n_type;
            r_hist      <= n_hist;
            r_mask      <= n_mask;
        end
    end

    assign o_push          = i_accept & w_emit;
    assign o_job.data      = w_data;
    assign o_job.last_idx  = w_last;
    assign o_job.stream    = n_streaming;

endmodule

// File: src/ps2m_queue.sv
// Small FIFO of reply runs between the front end and the byte serialiser.
module ps2m_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ps2m_pkg::t_job      i_job,
    input  logic                i_pop,
    output ps2m_pkg::t_job      o_head,
    output ps2m_pkg::t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ps2m_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push & ~o_status.full;
    assign w_pop  = i_pop  & ~o_status.empty;
    assign o_head = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/ps2m_back.sv
// Back end: sends each queued run one byte per word through an output register.
module ps2m_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ps2m_pkg::t_job      i_head,
    input  ps2m_pkg::t_q_status i_status,
    output logic                o_pop,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [7:0]          o_tdata,
    output logic                o_tlast,
    output logic                o_tuser
);

    logic       r_tvalid;
    logic [7:0] r_tdata;
    logic       r_tlast;
    logic       r_tuser;
    logic [1:0] r_idx;
    logic       w_load, w_end;

    assign w_load = (~r_tvalid | i_tready) & ~i_status.empty;
    assign w_end  = (r_idx == i_head.last_idx);
    assign o_pop  = w_load & w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_idx    <= 2'd0;
        end else begin
            if (w_load) begin
                r_tvalid <= 1'b1;
                r_idx    <= w_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tdata <= i_head.data[r_idx];
            r_tlast <= w_end;
            r_tuser <= i_head.stream;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;
    assign o_tuser  = r_tuser;

endmodule

// File: src/ps2_mouse_device_emulator_core.sv
// PS/2 mouse device core: command replies and movement packets as a byte stream.
//
// Takes one input word per cycle while the run queue has room. Host command
// bytes get an ack (0xFA) plus up to three reply bytes; button and motion
// words give a 3-byte packet while selected and streaming, or 4 bytes once the
// mouse type has been raised to wheel or five-button. All state is updated in
// the cycle a word is taken. The serialiser puts out one byte per cycle while
// the output side is ready and a run is queued, so a word yields as many
// output bytes as it has reply bytes (1 to 4); words with no reply queue
// nothing. QUEUE_DEPTH runs can wait between decode and output, so input keeps
// flowing while the output side is stalled until the queue fills.
module ps2_mouse_device_emulator_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,     // ps2_mouse_selected
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] host_byte, [15:8] prev_host_byte, [19:16] button_number,
    // [20] button_pressed, [28:21] move_x, [36:29] move_y,
    // [44:37] wheel_h, [52:45] wheel_v, [55:53] zero
    input  logic [55:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,    // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser     // [0] reporting_enabled
);

    logic                r_selected;
    logic                w_accept;
    logic                w_push, w_pop;
    ps2m_pkg::t_job      w_job, w_head;
    ps2m_pkg::t_q_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_selected <= 1'b1;
        end else if (i_cfg_we) begin
            r_selected <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = ~w_status.full;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    ps2m_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_selected       (r_selected),
        .i_kind           (s_axis_tuser),
        .i_host_byte      (s_axis_tdata[7:0]),
        .i_prev_host_byte (s_axis_tdata[15:8]),
        .i_button_number  (s_axis_tdata[19:16]),
        .i_button_pressed (s_axis_tdata[20]),
        .i_move_x         (s_axis_tdata[28:21]),
        .i_move_y         (s_axis_tdata[36:29]),
        .i_wheel_h        (s_axis_tdata[44:37]),
        .i_wheel_v        (s_axis_tdata[52:45]),
        .o_push           (w_push),
        .o_job            (w_job)
    );

    ps2m_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_job),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    ps2m_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_status (w_status),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the PS/2 mouse device core: command replies and packets.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic [7:0] wv;
        logic [7:0] wh;
        logic [7:0] my;
        logic [7:0] mx;
        logic       pressed;
        logic [3:0] btn;
        logic [7:0] prev;
        logic [7:0] host;
    } t_mouse_fields;

    typedef struct {
        logic [1:0]    kind;
        t_mouse_fields f;
    } t_mouse_word;

    typedef struct packed {
        logic [7:0] data_b;
        logic       last;
        logic       rep;
    } t_reply_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    t_mouse_word pend_words[$];
    t_reply_byte reply_q[$];
    t_mouse_word drv_word;
    t_reply_byte got_reply;

    // Mirror of the device state
    logic        sel_model;
    logic        streaming;
    logic [2:0]  mtype;
    logic [23:0] rate_hist;
    logic [7:0]  btn_mask;

    int err_cnt = 0;
    int stall_cycles = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;

    ps2_mouse_device_emulator_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        err_cnt++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Work out the reply bytes for one accepted word and update the mirrored state
    task automatic predict_replies(input logic [1:0] kind, input t_mouse_fields f);
        logic [7:0] reply_bytes [4];
        logic [7:0] x, y, h, v, b1, b3, b4;
        int n;
        int idx;
        logic do_pkt;
        n = 0;
        do_pkt = 1'b0;
        x = '0;
        y = '0;
        h = '0;
        v = '0;
        case (kind)
            ps2m_pkg::KIND_HOST: begin
                reply_bytes[0] = ps2m_pkg::RSP_ACK;
                n = 1;
                if (f.prev == ps2m_pkg::CMD_SET_RATE) begin
                    rate_hist = {rate_hist[15:0], f.host};
                    if (mtype == ps2m_pkg::TYPE_BASIC && rate_hist == ps2m_pkg::SEQ_WHEEL) begin
                        mtype = ps2m_pkg::TYPE_WHEEL;
                    end else if (mtype == ps2m_pkg::TYPE_WHEEL
                                 && rate_hist == ps2m_pkg::SEQ_FIVE) begin
                        mtype = ps2m_pkg::TYPE_FIVE;
                    end
                end else begin
                    case (f.host)
                        ps2m_pkg::CMD_RESET: begin
                            streaming = 1'b0;
                            mtype = ps2m_pkg::TYPE_BASIC;
                            reply_bytes[1] = ps2m_pkg::RSP_BAT_OK;
                            reply_bytes[2] = ps2m_pkg::RSP_ZERO;
                            n = 3;
                        end
                        ps2m_pkg::CMD_DEFAULTS: begin
                            streaming = 1'b0;
                            mtype = ps2m_pkg::TYPE_BASIC;
                        end
                        ps2m_pkg::CMD_DISABLE, ps2m_pkg::CMD_STREAM_MODE: streaming = 1'b0;
                        ps2m_pkg::CMD_ENABLE: streaming = 1'b1;
                        ps2m_pkg::CMD_GET_ID: begin
                            reply_bytes[1] = {5'b00000, mtype};
                            n = 2;
                        end
                        ps2m_pkg::CMD_STATUS: begin
                            reply_bytes[1] = ps2m_pkg::RSP_ZERO;
                            reply_bytes[2] = ps2m_pkg::RSP_STAT_RES;
                            reply_bytes[3] = ps2m_pkg::RSP_STAT_RATE;
                            n = 4;
                        end
                        default: ;
                    endcase
                end
            end
            ps2m_pkg::KIND_BUTTON: begin
                if (sel_model) begin
                    idx = int'(f.btn) - 1;
                    // out-of-range button leaves the mask alone but still reports
                    if (idx >= 0 && idx < 8) begin
                        btn_mask[idx] = f.pressed;
                    end
                    do_pkt = 1'b1;
                end
            end
            ps2m_pkg::KIND_MOTION: begin
                if (sel_model) begin
                    x = f.mx;
                    y = f.my;
                    h = f.wh;
                    v = f.wv;
                    do_pkt = 1'b1;
                end
            end
            default: ;
        endcase

        if (do_pkt && streaming) begin
            b1 = ps2m_pkg::PKT_SYNC | {5'b00000, btn_mask[2:0]};
            b3 = -y;
            if (x[7]) b1[4] = 1'b1;
            if (b3[7]) b1[5] = 1'b1;
            reply_bytes[0] = b1;
            reply_bytes[1] = x;
            reply_bytes[2] = b3;
            n = 3;
            if (mtype == ps2m_pkg::TYPE_WHEEL || mtype == ps2m_pkg::TYPE_FIVE) begin
                b4 = 8'h00;
                if (v[7]) b4 = ps2m_pkg::WHL_UP;
                else if (v != 8'h00) b4 = ps2m_pkg::WHL_DOWN;
                // horizontal wheel wins over vertical
                if (h[7]) b4 = ps2m_pkg::WHL_LEFT;
                else if (h != 8'h00) b4 = ps2m_pkg::WHL_RIGHT;
                if (mtype == ps2m_pkg::TYPE_FIVE) begin
                    b4 = {2'b00, btn_mask[4], btn_mask[3], b4[3:0]};
                end
                reply_bytes[3] = b4;
                n = 4;
            end
        end

        for (int k = 0; k < n; k++) begin
            reply_q.push_back('{reply_bytes[k], k == n - 1, streaming});
        end
    endtask

    function automatic t_mouse_word rand_word();
        t_mouse_word w;
        w.kind = 2'($urandom_range(0, 3));
        w.f = 53'({$urandom, $urandom});
        return w;
    endfunction

    task automatic push_host(input logic [7:0] host, input logic [7:0] prev);
        t_mouse_word w;
        w = rand_word();
        w.kind = ps2m_pkg::KIND_HOST;
        w.f.host = host;
        w.f.prev = prev;
        pend_words.push_back(w);
    endtask

    task automatic push_button(input logic [3:0] btn, input logic pressed);
        t_mouse_word w;
        w = rand_word();
        w.kind = ps2m_pkg::KIND_BUTTON;
        w.f.btn = btn;
        w.f.pressed = pressed;
        pend_words.push_back(w);
    endtask

    task automatic push_motion(input logic [7:0] mx, my, wh, wv);
        t_mouse_word w;
        w = rand_word();
        w.kind = ps2m_pkg::KIND_MOTION;
        w.f.mx = mx;
        w.f.my = my;
        w.f.wh = wh;
        w.f.wv = wv;
        pend_words.push_back(w);
    endtask

    task automatic push_spare();
        t_mouse_word w;
        w = rand_word();
        w.kind = KIND_SPARE;
        pend_words.push_back(w);
    endtask

    // Mostly well-formed traffic: enables, rate sequences, buttons and motion
    task automatic queue_random(input int n_items);
        int cnt, r, pick, n_seq;
        logic [23:0] magic;
        logic [7:0] cmd, prev;
        cnt = 0;
        while (cnt < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                pick = $urandom_range(0, 3);
                n_seq = (pick == 2) ? 2 : 1;
                for (int s = 0; s < n_seq; s++) begin
                    magic = (pick == 1 || s == 1) ? ps2m_pkg::SEQ_FIVE : ps2m_pkg::SEQ_WHEEL;
                    if (pick == 3) magic[15:8] = 8'($urandom);
                    if ($urandom_range(0, 1) == 1) begin
                        push_host(ps2m_pkg::CMD_SET_RATE, 8'($urandom));
                        cnt++;
                    end
                    for (int k = 0; k < 3; k++) begin
                        push_host(magic[23 - 8 * k -: 8], ps2m_pkg::CMD_SET_RATE);
                    end
                    cnt += 3;
                end
            end else if (r < 35) begin
                if (r < 20) begin
                    cmd = ps2m_pkg::CMD_ENABLE;
                end else begin
                    case ($urandom_range(0, 8))
                        0: cmd = ps2m_pkg::CMD_RESET;
                        1: cmd = ps2m_pkg::CMD_DEFAULTS;
                        2: cmd = ps2m_pkg::CMD_DISABLE;
                        3: cmd = ps2m_pkg::CMD_STREAM_MODE;
                        4: cmd = ps2m_pkg::CMD_GET_ID;
                        5: cmd = ps2m_pkg::CMD_STATUS;
                        6: cmd = ps2m_pkg::CMD_SET_RATE;
                        7: cmd = ps2m_pkg::CMD_ENABLE;
                        default: cmd = 8'($urandom);
                    endcase
                end
                prev = ($urandom_range(0, 7) == 0) ? ps2m_pkg::CMD_SET_RATE : 8'($urandom);
                push_host(cmd, prev);
                cnt++;
            end else if (r < 55) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_button(4'($urandom_range(0, 15)), 1'($urandom));
                end else begin
                    push_button(4'($urandom_range(1, 8)), 1'($urandom));
                end
                cnt++;
            end else if (r < 97) begin
                push_motion(8'($urandom), 8'($urandom),
                            ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom),
                            ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
                cnt++;
            end else begin
                push_spare();
                cnt++;
            end
        end
    endtask

    // Wait until every word is taken and every reply byte seen, then let the core settle
    task automatic wait_quiet();
        while (pend_words.size() != 0 || s_axis_tvalid || reply_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_selected(input logic value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pend_words.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                drv_word = pend_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= drv_word.kind;
                s_axis_tdata <= {3'b000, drv_word.f};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Monitor: predict on accepted input words, check accepted output words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sel_model = 1'b1;
            streaming = 1'b0;
            mtype = ps2m_pkg::TYPE_BASIC;
            rate_hist = '0;
            btn_mask = '0;
            reply_q.delete();
        end else begin
            if (i_cfg_we) sel_model = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_replies(s_axis_tuser, t_mouse_fields'(s_axis_tdata[52:0]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (reply_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
                end else begin
                    got_reply = reply_q.pop_front();
                    if (m_axis_tdata !== got_reply.data_b) begin
                        report_mismatch($sformatf("byte %02h, want %02h",
                                                  m_axis_tdata, got_reply.data_b));
                    end
                    if (m_axis_tlast !== got_reply.last) begin
                        report_mismatch($sformatf("tlast %b, want %b on byte %02h",
                                                  m_axis_tlast, got_reply.last,
                                                  got_reply.data_b));
                    end
                    if (m_axis_tuser !== got_reply.rep) begin
                        report_mismatch($sformatf("reporting %b, want %b on byte %02h",
                                                  m_axis_tuser, got_reply.rep,
                                                  got_reply.data_b));
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        snd_idle_pct = 11;
        rcv_idle_pct = 78;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_selected(1'b1);

        // Directed: type promotion, wheel codes, odd buttons, replies
        push_spare();
        push_host(ps2m_pkg::CMD_GET_ID, 8'h00);
        push_button(4'd1, 1'b1);            // not streaming yet: no packet
        push_host(ps2m_pkg::CMD_ENABLE, 8'h00);
        push_motion(8'h7F, 8'h80, 8'h00, 8'h00);
        push_motion(8'h80, 8'h7F, 8'h00, 8'h00);
        push_host(ps2m_pkg::CMD_SET_RATE, 8'h00);
        push_host(ps2m_pkg::SEQ_WHEEL[23:16], ps2m_pkg::CMD_SET_RATE);
        push_host(ps2m_pkg::SEQ_WHEEL[15:8], ps2m_pkg::CMD_SET_RATE);
        push_host(ps2m_pkg::SEQ_WHEEL[7:0], ps2m_pkg::CMD_SET_RATE);
        push_host(ps2m_pkg::CMD_GET_ID, 8'h00);
        push_motion(8'h00, 8'h00, 8'h00, 8'hFF);
        push_motion(8'h01, 8'hFF, 8'h80, 8'h01);
        push_motion(8'hFF, 8'h01, 8'h7F, 8'h00);
        push_host(ps2m_pkg::SEQ_FIVE[23:16], ps2m_pkg::CMD_SET_RATE);
        push_host(ps2m_pkg::SEQ_FIVE[15:8], ps2m_pkg::CMD_SET_RATE);
        push_host(ps2m_pkg::SEQ_FIVE[7:0], ps2m_pkg::CMD_SET_RATE);
        push_button(4'd4, 1'b1);
        push_button(4'd5, 1'b1);
        push_button(4'd0, 1'b1);
        push_button(4'd8, 1'b1);
        push_motion(8'h00, 8'h00, 8'h00, 8'h80);
        push_host(ps2m_pkg::CMD_RESET, ps2m_pkg::CMD_SET_RATE);  // rate byte, not a reset
        push_host(ps2m_pkg::CMD_STATUS, 8'h00);
        push_host(ps2m_pkg::CMD_STREAM_MODE, 8'h00);
        push_motion(8'h10, 8'h10, 8'h01, 8'h01);
        push_host(ps2m_pkg::CMD_RESET, 8'h00);
        wait_quiet();

        // Deselected: buttons and motion are dropped
        set_selected(1'b0);
        push_host(ps2m_pkg::CMD_ENABLE, 8'h00);
        push_button(4'd2, 1'b1);
        push_motion(8'h05, 8'hFB, 8'h00, 8'h01);
        push_host(ps2m_pkg::CMD_DEFAULTS, 8'h00);
        wait_quiet();

        set_selected(1'b1);
        queue_random(50);
        wait_quiet();
        queue_random(20);
        wait_quiet();

        snd_idle_pct = 78;
        rcv_idle_pct = 11;
        set_selected(1'b0);
        queue_random(30);
        wait_quiet();
        set_selected(1'b1);
        queue_random(50);
        wait_quiet();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        queue_random(25);
        wait_quiet();
        queue_random(25);
        wait_quiet();

        if (err_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
